### sv/seconds_counter_calendar_unit_assert.svh
// Assertion macros for the calendar unit's datapath.
`ifndef SECONDS_COUNTER_CALENDAR_UNIT_ASSERT_SVH
`define SECONDS_COUNTER_CALENDAR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/scc_pkg.sv
package scc_pkg;

   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_MIN  = 60;

   // Each divisor splits into a power of two, taken off by a shift, and an odd
   // part d. The odd part is divided by multiplying with ceil(2^k / d) and
   // dropping k bits. The quotient is exact over the whole range of the
   // shifted operand: 25 bits for the day, 13 for the hour, 10 for the minute.
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 86400 = 2^7 * 675, k = 35
   localparam logic [13:0] HOUR_RECIP = 14'd9321;      // 3600 = 2^4 * 225, k = 21
   localparam logic [10:0] MIN_RECIP  = 11'd1093;      // 60 = 2^2 * 15, k = 14

   localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
   localparam logic [3:0]  LAST_MONTH    = 4'd11;
   localparam logic [3:0]  FEBRUARY      = 4'd1;
   localparam logic [3:0]  JULY          = 4'd6;

   typedef enum logic [1:0] {
      DIV_DAY,
      DIV_HOUR,
      DIV_MIN
   } div_sel_type;

   typedef struct packed {
      logic        load;        // take the input item and start the day division
      logic        div_step;    // a step of the current division
      logic        div_last;    // remainder cycle of the current division
      div_sel_type div_sel;     // which division is running
      logic        year_step;   // remove one whole year from the day count
      logic        month_step;  // remove one whole month from the day count
      logic        emit;        // copy the breakdown into the result register
   } cmd_type;

   typedef struct packed {
      logic year_more;   // remaining days cover the current year
      logic month_more;  // remaining days cover the current month
      logic out_free;    // result register can take a new item this cycle
   } status_type;

   // Years reached from a 32-bit count lie in 1970..2106, where the only
   // century that is not a leap year is 2100.
   function automatic logic leap_year(input logic [11:0] y);
      return (y[1:0] == 2'b00) && (y != 12'd2100);
   endfunction

   function automatic logic [8:0] days_in_year(input logic [11:0] y);
      return leap_year(y) ? 9'd366 : 9'd365;
   endfunction

   // Month index runs 0..11 with January as 0.
   function automatic logic [4:0] days_in_month(input logic leap, input logic [3:0] m);
      logic [3:0] mm;
      mm = (m > JULY) ? (m - 4'd1) : m;
      if (m == FEBRUARY) begin
         return leap ? 5'd29 : 5'd28;
      end
      return mm[0] ? 5'd30 : 5'd31;
   endfunction

endpackage

### sv/scc_ctrl.sv
module scc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output scc_pkg::cmd_type    cmd,
   input  scc_pkg::status_type status
);
   import scc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DAY,
      ST_HOUR,
      ST_MIN,
      ST_YEAR,
      ST_MONTH,
      ST_EMIT
   } state_type;

   // Each division takes a quotient step and then a remainder step.
   state_type  state_ff;
   logic       step_ff;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd = '0;
      cmd.div_sel = DIV_DAY;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
         end
         ST_DAY: begin
            cmd.div_step = 1'b1;
            cmd.div_last = step_ff;
            cmd.div_sel  = DIV_DAY;
         end
         ST_HOUR: begin
            cmd.div_step = 1'b1;
            cmd.div_last = step_ff;
            cmd.div_sel  = DIV_HOUR;
         end
         ST_MIN: begin
            cmd.div_step = 1'b1;
            cmd.div_last = step_ff;
            cmd.div_sel  = DIV_MIN;
         end
         ST_YEAR: begin
            cmd.year_step = status.year_more;
         end
         ST_MONTH: begin
            cmd.month_step = status.month_more;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_DAY;
                  step_ff  <= 1'b0;
               end
            end
            ST_DAY: begin
               if (step_ff) begin
                  state_ff <= ST_HOUR;
                  step_ff  <= 1'b0;
               end else begin
                  step_ff <= 1'b1;
               end
            end
            ST_HOUR: begin
               if (step_ff) begin
                  state_ff <= ST_MIN;
                  step_ff  <= 1'b0;
               end else begin
                  step_ff <= 1'b1;
               end
            end
            ST_MIN: begin
               if (step_ff) begin
                  state_ff <= ST_YEAR;
                  step_ff  <= 1'b0;
               end else begin
                  step_ff <= 1'b1;
               end
            end
            ST_YEAR: begin
               if (!status.year_more) begin
                  state_ff <= ST_MONTH;
               end
            end
            ST_MONTH: begin
               if (!status.month_more) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### sv/scc_dp.sv
module scc_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tuser,   // kind
   input  logic [31:0]         req_tdata,   // new_seconds
   input  scc_pkg::cmd_type    cmd,
   output scc_pkg::status_type status,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [71:0]         rsp_tdata    // epoch_seconds, second, minute, hour,
                                            // day, month, year, two zero bits
);
   import scc_pkg::*;

   `include "seconds_counter_calendar_unit_assert.svh"

   logic [31:0] count_ff,   count_in;
   logic [31:0] work_ff,    work_in;
   logic [15:0] quot_ff,    quot_in;
   logic [15:0] days_ff,    days_in;
   logic [4:0]  hour_ff,    hour_in;
   logic [5:0]  minute_ff,  minute_in;
   logic [11:0] year_ff,    year_in;
   logic [3:0]  month_ff,   month_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff,  rsp_data_in;

   logic [50:0] day_prod;
   logic [26:0] hour_prod;
   logic [20:0] min_prod;
   logic [15:0] recip_quot;
   logic [31:0] div_const;
   logic [31:0] back_prod;
   logic [8:0]  year_len;
   logic [4:0]  month_len;
   logic [4:0]  day_one;
   logic [3:0]  month_one;
   logic        month_ok;
   logic        day_ok;

   // Reciprocal products; the quotient sits above the dropped k bits.
   assign day_prod  = 51'(work_ff[31:7]) * 51'(DAY_RECIP);
   assign hour_prod = 27'(work_ff[16:4]) * 27'(HOUR_RECIP);
   assign min_prod  = 21'(work_ff[11:2]) * 21'(MIN_RECIP);
   assign back_prod = 32'(quot_ff) * div_const;

   assign year_len  = days_in_year(year_ff);
   assign month_len = days_in_month(leap_year(year_ff), month_ff);
   assign day_one   = days_ff[4:0] + 5'd1;
   assign month_one = month_ff + 4'd1;

   assign status.year_more  = (days_ff >= 16'(year_len));
   assign status.month_more = (month_ff < LAST_MONTH) && (days_ff >= 16'(month_len));
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      recip_quot = day_prod[50:35];
      div_const  = 32'(SECS_PER_DAY);
      unique case (cmd.div_sel)
         DIV_DAY: begin
            recip_quot = day_prod[50:35];
            div_const  = 32'(SECS_PER_DAY);
         end
         DIV_HOUR: begin
            recip_quot = {11'd0, hour_prod[25:21]};
            div_const  = 32'(SECS_PER_HOUR);
         end
         DIV_MIN: begin
            recip_quot = {10'd0, min_prod[19:14]};
            div_const  = 32'(SECS_PER_MIN);
         end
         default: begin
            recip_quot = day_prod[50:35];
            div_const  = 32'(SECS_PER_DAY);
         end
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      work_in    = work_ff;
      quot_in    = quot_ff;
      days_in    = days_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      year_in    = year_ff;
      month_in   = month_ff;

      if (cmd.load) begin
         count_in   = req_tuser ? req_tdata : (count_ff + 32'd1);
         work_in    = count_in;
      end

      if (cmd.div_step) begin
         if (!cmd.div_last) begin
            quot_in = recip_quot;
         end else begin
            work_in = work_ff - back_prod;
            unique case (cmd.div_sel)
               DIV_DAY: begin
                  days_in = quot_ff;
               end
               DIV_HOUR: begin
                  hour_in = quot_ff[4:0];
               end
               DIV_MIN: begin
                  minute_in = quot_ff[5:0];
                  year_in   = EPOCH_YEAR;
                  month_in  = '0;
               end
               default: begin
                  work_in = work_ff;
               end
            endcase
         end
      end

      if (cmd.year_step) begin
         days_in = days_ff - 16'(year_len);
         year_in = year_ff + 12'd1;
      end

      if (cmd.month_step) begin
         days_in  = days_ff - 16'(month_len);
         month_in = month_ff + 4'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, year_ff, month_one, day_one, hour_ff, minute_ff,
                         work_ff[5:0], count_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      quot_ff     <= quot_in;
      days_ff     <= days_in;
      hour_ff     <= hour_in;
      minute_ff   <= minute_in;
      year_ff     <= year_in;
      month_ff    <= month_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign month_ok = (rsp_data_ff[57:54] != 4'd0) && (rsp_data_ff[57:54] <= 4'd12);
   assign day_ok   = (rsp_data_ff[53:49] != 5'd0) && (rsp_data_ff[48:44] < 5'd24);

   `SCC_ASSERT_NEXT(a_emit_sets_valid, cmd.emit, rsp_valid_ff, "result lost after emit")
   `SCC_ASSERT_NOW(a_month_range, rsp_valid_ff, month_ok, "month out of range")
   `SCC_ASSERT_NOW(a_day_range, rsp_valid_ff, day_ok, "day or hour out of range")

endmodule

### sv/seconds_counter_calendar_unit.sv
// Channel   Ports                      Contents (lowest bit first)
// req       req_tvalid/tready/tuser    tuser: kind; tdata[31:0]: new_seconds
// rsp       rsp_tvalid/tready/tdata    tdata: epoch_seconds, second, minute,
//                                      hour, day, month, year, two zero bits
//
// An item is accepted, then goes through the day, hour and minute divisions (a
// reciprocal multiply step and a remainder step each), the year walk, removing
// one whole year past 1970 per step, the month walk, removing one whole month per
// step, and the result load. The year walk dominates. Reset is synchronous and
// returns the count to zero (1970-01-01 00:00:00) with no result pending. A
// stalled result waits in its own register while the next item is accepted and
// worked on; that item then holds in the result load until the register is free.
module seconds_counter_calendar_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // [0] kind: 0 tick, 1 load
   input  logic [31:0] req_tdata,   // [31:0] new_seconds

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [31:0] epoch_seconds, [37:32] second_of_minute,
                                    // [43:38] minute_of_hour, [48:44] hour_of_day,
                                    // [53:49] day_of_month, [57:54] month_of_year,
                                    // [69:58] year_number, [71:70] zero
);
   import scc_pkg::*;

   // The controller sequences the divisions and walks; the datapath holds the
   // count, the working registers and the result register.
   cmd_type    cmd;
   status_type status;

   scc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   scc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### tb/tb_seconds_counter_calendar_unit.sv
`timescale 1ns / 1ps

module tb_seconds_counter_calendar_unit;

   import scc_pkg::*;

   // The request kind travels alone in req_tuser.
   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_LOAD = 1'b1
   } item_kind_type;

   // Field order matches rsp_tdata[69:0], highest field first.
   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [31:0] count;
   } calendar_type;

   // One row of the directed table. A pinned row carries its date typed in;
   // the others are checked against the calendar predictor below.
   typedef struct packed {
      item_kind_type kind;
      logic [31:0]   value;
      logic          pinned;
      calendar_type  date;
   } stim_row_type;

   localparam int unsigned NUM_DIRECTED = 24;
   localparam int unsigned TOTAL_ITEMS  = 1850;
   localparam int unsigned IDLE_PCT     = 28;
   localparam int unsigned HOLD_CYCLES  = 600;
   localparam int unsigned DRAIN_CYCLES = 250;
   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned STEADY_FROM  = 700;
   localparam int unsigned STEADY_TO    = 1000;
   localparam int unsigned HOLD_AT      = 300;

   localparam stim_row_type DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
      // The first tick after reset moves the epoch on by one second.
      '{KIND_TICK, 32'd0,          1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd1,
                                           32'd1}},
      '{KIND_LOAD, 32'd0,          1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,
                                           32'd0}},
      // Largest count, then a tick that wraps back to the epoch while its
      // data field is all ones and must be ignored.
      '{KIND_LOAD, 32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15,
                                           32'hFFFF_FFFF}},
      '{KIND_TICK, 32'hFFFF_FFFF,  1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,
                                           32'd0}},
      '{KIND_TICK, 32'h5A5A_A5A5,  1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd1,
                                           32'd1}},
      '{KIND_LOAD, 32'd86399,      1'b1, '{12'd1970, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59,
                                           32'd86399}},
      '{KIND_TICK, 32'd0,          1'b1, '{12'd1970, 4'd1,  5'd2,  5'd0,  6'd0,  6'd0,
                                           32'd86400}},
      '{KIND_LOAD, 32'd2678399,    1'b0, '0},
      '{KIND_TICK, 32'd0,          1'b0, '0},
      '{KIND_LOAD, 32'd31535999,   1'b0, '0},
      '{KIND_TICK, 32'd0,          1'b0, '0},
      '{KIND_LOAD, 32'd946684799,  1'b0, '0},
      '{KIND_TICK, 32'd0,          1'b0, '0},
      // Into and out of the leap day of a century year that is a leap year.
      '{KIND_LOAD, 32'd951782399,  1'b0, '0},
      '{KIND_TICK, 32'd0,          1'b0, '0},
      '{KIND_LOAD, 32'd951868799,  1'b0, '0},
      '{KIND_TICK, 32'd0,          1'b0, '0},
      // End of February in 2100, a century year without a leap day.
      '{KIND_LOAD, 32'd4107542399, 1'b0, '0},
      '{KIND_TICK, 32'd0,          1'b0, '0},
      '{KIND_LOAD, 32'd2147483647, 1'b0, '0},
      '{KIND_TICK, 32'd0,          1'b0, '0},
      '{KIND_LOAD, 32'd1234567890, 1'b0, '0},
      '{KIND_LOAD, 32'd4102444799, 1'b0, '0},
      '{KIND_TICK, 32'd0,          1'b0, '0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser  = 1'b0;   // [0] kind
   logic [31:0] req_tdata  = '0;     // [31:0] new_seconds
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;           // [31:0] epoch_seconds, [37:32] second_of_minute,
                                     // [43:38] minute_of_hour, [48:44] hour_of_day,
                                     // [53:49] day_of_month, [57:54] month_of_year,
                                     // [69:58] year_number, [71:70] zero

   // Dates still owed by the block, oldest first.
   calendar_type pending_dates [$];

   // Predictor copy of the seconds counter.
   logic [31:0] tracked_count = '0;

   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   int unsigned items_sent    = 0;
   int unsigned loads_sent    = 0;
   int unsigned ticks_sent    = 0;
   int unsigned dates_checked = 0;
   int unsigned wraps_seen    = 0;
   int unsigned lowest_year   = 9999;
   int unsigned highest_year  = 0;

   // Set by the stimulus side, read by the result side.
   bit          steady_phase  = 1'b0;
   bit          hold_request  = 1'b0;

   seconds_counter_calendar_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Full Gregorian rule, even though only 2100 matters in this range.
   function automatic bit is_leap(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned year_length(input int unsigned y);
      return is_leap(y) ? 366 : 365;
   endfunction

   // Months are indexed 0..11 here, January first.
   function automatic int unsigned month_length(input bit leap, input int unsigned m);
      if (m == 1) begin
         return leap ? 29 : 28;
      end
      if (m == 3 || m == 5 || m == 8 || m == 10) begin
         return 30;
      end
      return 31;
   endfunction

   // Breaks a seconds count down into the calendar date the block must return.
   function automatic calendar_type calendar_of(input logic [31:0] count);
      calendar_type date;
      int unsigned  days;
      int unsigned  in_day;
      int unsigned  yr;
      int unsigned  mo;
      days   = count / SECS_PER_DAY;
      in_day = count % SECS_PER_DAY;
      yr     = EPOCH_YEAR;
      while (days >= year_length(yr)) begin
         days -= year_length(yr);
         yr++;
      end
      mo = 0;
      while (mo < 11 && days >= month_length(is_leap(yr), mo)) begin
         days -= month_length(is_leap(yr), mo);
         mo++;
      end
      date.count  = count;
      date.second = 6'(in_day % SECS_PER_MIN);
      date.minute = 6'((in_day % SECS_PER_HOUR) / SECS_PER_MIN);
      date.hour   = 5'(in_day / SECS_PER_HOUR);
      date.day    = 5'(days + 1);
      date.month  = 4'(mo + 1);
      date.year   = 12'(yr);
      return date;
   endfunction

   // Seconds count at midnight on the first day of month mo (0..11) of year yr.
   function automatic logic [31:0] month_start(input int unsigned yr, input int unsigned mo);
      longint unsigned days;
      days = 0;
      for (int unsigned y = EPOCH_YEAR; y < yr; y++) begin
         days += year_length(y);
      end
      for (int unsigned m = 0; m < mo; m++) begin
         days += month_length(is_leap(yr), m);
      end
      return 32'(days * SECS_PER_DAY);
   endfunction

   // Offers one item, after a random gap outside the steady window, and waits until
   // it is accepted. On acceptance the predictor advances and the date owed is queued.
   task automatic send_item(input item_kind_type kind, input logic [31:0] value,
                            input logic pinned, input calendar_type pinned_date);
      calendar_type owed;
      while (!steady_phase && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do begin
         @(posedge clock);
      end while (!req_tready);

      if (kind == KIND_LOAD) begin
         tracked_count = value;
         loads_sent++;
      end else begin
         if (tracked_count == 32'hFFFF_FFFF) begin
            wraps_seen++;
         end
         tracked_count = tracked_count + 32'd1;
         ticks_sent++;
      end
      owed = pinned ? pinned_date : calendar_of(tracked_count);
      pending_dates.push_back(owed);
      if (owed.year < lowest_year) begin
         lowest_year = owed.year;
      end
      if (owed.year > highest_year) begin
         highest_year = owed.year;
      end
      items_sent++;
   endtask

   task automatic compare_field(input string name, input longint unsigned want,
                                input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Stimulus: reset, the directed table, then random segments. Most
   // segments load a count just short of a month, day or wrap boundary and
   // then tick up to or across it, so the carry chain from seconds up to the year is
   // exercised in every combination; the rest are fully random loads and
   // stray ticks.
   initial begin
      int unsigned pick;
      int unsigned yr;
      int unsigned mo;
      int unsigned run;
      logic [31:0] start;
      bit          with_load;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int unsigned i = 0; i < NUM_DIRECTED; i++) begin
         send_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].value,
                   DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].date);
      end

      while (items_sent < TOTAL_ITEMS) begin
         // A window with no idling on either side, and one long result stall
         // while the stimulus keeps coming so that the input backs up.
         steady_phase = (items_sent >= STEADY_FROM) && (items_sent < STEADY_TO);
         if (items_sent >= HOLD_AT) begin
            hold_request = 1'b1;
         end

         pick      = $urandom_range(0, 99);
         with_load = 1'b1;
         if (pick < 45) begin
            yr    = $urandom_range(EPOCH_YEAR, 2106);
            mo    = (yr == 2106) ? $urandom_range(0, 1) : $urandom_range(0, 11);
            start = month_start(yr, mo) - 32'($urandom_range(1, 3));
            run   = $urandom_range(1, 6);
         end else if (pick < 65) begin
            start = $urandom();
            run   = $urandom_range(0, 4);
         end else if (pick < 80) begin
            start = 32'($urandom_range(0, 49710)) * 32'(SECS_PER_DAY)
                    - 32'($urandom_range(1, 3));
            run   = $urandom_range(1, 5);
         end else if (pick < 90) begin
            start = 32'hFFFF_FFFF - 32'($urandom_range(0, 4));
            run   = $urandom_range(1, 6);
         end else begin
            start     = '0;
            with_load = 1'b0;
            run       = $urandom_range(1, 8);
         end

         if (with_load) begin
            send_item(KIND_LOAD, start, 1'b0, '0);
         end
         repeat (run) send_item(KIND_TICK, $urandom(), 1'b0, '0);
      end
      req_tvalid   <= 1'b0;
      steady_phase  = 1'b0;

      while (pending_dates.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d items (%0d loads, %0d ticks), %0d dates checked.",
               items_sent, loads_sent, ticks_sent, dates_checked);
      $display("Summary: years %0d to %0d reached, %0d wraps through zero.",
               lowest_year, highest_year, wraps_seen);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Result side: checks each accepted date against the oldest one owed and
   // stalls at random. The long hold-off is counted here, in cycles.
   initial begin
      calendar_type got;
      calendar_type want;
      int unsigned  hold_left;
      bit           hold_served;
      hold_left   = 0;
      hold_served = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = calendar_type'(rsp_tdata[69:0]);
            if (pending_dates.size() == 0) begin
               $error("result with no date owed: epoch_seconds %0d", got.count);
               error_count++;
            end else begin
               want = pending_dates.pop_front();
               compare_field("epoch_seconds",    want.count,  got.count);
               compare_field("second_of_minute", want.second, got.second);
               compare_field("minute_of_hour",   want.minute, got.minute);
               compare_field("hour_of_day",      want.hour,   got.hour);
               compare_field("day_of_month",     want.day,    got.day);
               compare_field("month_of_year",    want.month,  got.month);
               compare_field("year_number",      want.year,   got.year);
               compare_field("zero_pad",         0,           rsp_tdata[71:70]);
               dates_checked++;
            end
         end

         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (steady_phase) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog: far above the slowest correct run, where every item walks
   // the full 2106 year range and every result waits out a stall.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule

### files.f
+incdir+sv
sv/scc_pkg.sv
sv/scc_ctrl.sv
sv/scc_dp.sv
sv/seconds_counter_calendar_unit.sv
tb/tb_seconds_counter_calendar_unit.sv
